// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define HTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define HTE_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- design/hte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_pkg
// Shared constants and types of the table-driven encoder and byte packer.
// ----------------------------------------------------------------------------
package hte_pkg;

  localparam int HTE_SYMBOLS   = 256;
  localparam int HTE_CODE_BITS = 32;
  localparam int HTE_QDEPTH    = 2;
  localparam int HTE_BYTE_BITS = 8;

  localparam int HTE_IN_DW  = 48;
  localparam int HTE_IN_UW  = 2;
  localparam int HTE_OUT_DW = 16;

  localparam int HTE_SYM_W  = 8;
  localparam int HTE_CODE_W = 32;
  localparam int HTE_LEN_W  = 6;
  localparam int HTE_PAD_W  = 3;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_ENC   = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  typedef enum logic [0:0] {
    KIND_ENC   = 1'b0,
    KIND_FLUSH = 1'b1
  } hte_kind_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hte_qstat_t;

endpackage

// ----- design/hte_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_fifo
// Short request queue between the table front end and the packer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hte_fifo import hte_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = HTE_QDEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output hte_qstat_t       stat
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNTW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  `HTE_ASSERT_NEVER(a_q_overflow, push && (cnt_r == CNTW'(DEPTH)), "queue written while full")
  `HTE_ASSERT_NEVER(a_q_underflow, pop && (cnt_r == '0), "queue read while empty")
  `HTE_ASSERT(a_q_count, push && !pop |=> cnt_r == $past(cnt_r) + 1'b1, "queue count slip")

endmodule

// ----- design/hte_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_front
// Accepts requests, keeps the code table and queues encode and flush work.
// ----------------------------------------------------------------------------
module hte_front import hte_pkg::*; #(
  parameter int SYMBOLS   = HTE_SYMBOLS,
  parameter int CODE_BITS = HTE_CODE_BITS,
  parameter int LW        = $clog2(CODE_BITS + 1),
  parameter int QW        = 1 + LW + CODE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [HTE_SYM_W-1:0]  symbol,
  input  logic [HTE_CODE_W-1:0] code_bits,
  input  logic [HTE_LEN_W-1:0]  code_length,
  input  hte_qstat_t            q_stat,
  output logic                  q_push,
  output logic [QW-1:0]         q_wdata
);

  localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam logic [HTE_LEN_W-1:0] LEN_MAX = HTE_LEN_W'(CODE_BITS);

  logic [CODE_BITS-1:0] code_mem [SYMBOLS];
  logic [LW-1:0]        len_mem  [SYMBOLS];
  logic [SYMBOLS-1:0]   hit_r;

  logic                 s1_vld_r, s1_vld_nxt;
  hte_kind_t            s1_kind_r, s1_kind_nxt;
  logic                 s1_hit_r;
  logic [CODE_BITS-1:0] rd_code_r;
  logic [LW-1:0]        rd_len_r;

  logic                 acc, sym_ok, do_load, do_enc, do_flush;
  logic [AW-1:0]        idx;
  logic [HTE_LEN_W-1:0] len_sat;
  logic [CODE_BITS-1:0] code_ext, code_mask;
  logic [LW-1:0]        eff_len;

  assign in_ready = !s1_vld_r || !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign sym_ok   = ({1'b0, symbol} < (HTE_SYM_W + 1)'(SYMBOLS));
  assign idx      = symbol[AW-1:0];

  always_comb begin
    do_load  = 1'b0;
    do_enc   = 1'b0;
    do_flush = 1'b0;
    case (func)
      FUNC_LOAD:  do_load  = acc && sym_ok;
      FUNC_ENC:   do_enc   = acc && sym_ok;
      FUNC_FLUSH: do_flush = acc;
      default: ;
    endcase
  end

  assign len_sat   = (code_length > LEN_MAX) ? LEN_MAX : code_length;
  assign code_ext  = CODE_BITS'({32'd0, code_bits});
  assign code_mask = ~({CODE_BITS{1'b1}} << len_sat);

  always_ff @(posedge clk) begin
    if (do_load) begin
      code_mem[idx] <= code_ext & code_mask;
      len_mem[idx]  <= len_sat[LW-1:0];
    end
    if (do_enc) begin
      rd_code_r <= code_mem[idx];
      rd_len_r  <= len_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= '0;
    end else if (do_load) begin
      hit_r[idx] <= 1'b1;
    end
  end

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    s1_kind_nxt = s1_kind_r;
    if (acc) begin
      s1_vld_nxt  = do_enc || do_flush;
      s1_kind_nxt = do_flush ? KIND_FLUSH : KIND_ENC;
    end else if (!q_stat.full) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s1_kind_r <= KIND_ENC;
      s1_hit_r  <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s1_kind_r <= s1_kind_nxt;
      if (do_enc) begin
        s1_hit_r <= hit_r[idx];
      end
    end
  end

  assign eff_len = s1_hit_r ? rd_len_r : '0;
  assign q_push  = s1_vld_r && !q_stat.full && ((s1_kind_r == KIND_FLUSH) || (eff_len != '0));
  assign q_wdata = {s1_kind_r, eff_len, rd_code_r};

endmodule

// ----- design/hte_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_back
// Bit packer: appends codes to the pending bits, sends whole bytes and pads the last bits on a flush.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hte_back import hte_pkg::*; #(
  parameter int CODE_BITS = HTE_CODE_BITS,
  parameter int LW        = $clog2(CODE_BITS + 1),
  parameter int QW        = 1 + LW + CODE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hte_qstat_t            q_stat,
  input  logic [QW-1:0]         q_rdata,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [HTE_OUT_DW-1:0] out_data,
  output logic                  out_user,
  output logic                  out_last
);

  localparam int WW = CODE_BITS + 7;
  localparam int TW = $clog2(CODE_BITS + 8);
  localparam logic [TW-1:0] T_BYTE = TW'(HTE_BYTE_BITS);

  logic [WW-1:0]         w_r, w_nxt;
  logic [TW-1:0]         tot_r, tot_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [HTE_OUT_DW-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  hte_kind_t             q_kind;
  logic [LW-1:0]         q_len;
  logic [CODE_BITS-1:0]  q_code;
  logic                  slot_free, emitting, load_out;
  logic [2:0]            pend_cnt;
  logic [6:0]            pend;
  logic [TW-1:0]         shamt;
  logic [7:0]            emit_byte, flush_byte;
  logic [HTE_PAD_W-1:0]  pad;

  assign q_kind = hte_kind_t'(q_rdata[QW-1]);
  assign q_len  = q_rdata[CODE_BITS +: LW];
  assign q_code = q_rdata[CODE_BITS-1:0];

  assign slot_free  = !out_vld_r || out_ready;
  assign emitting   = (tot_r >= T_BYTE);
  assign pend_cnt   = tot_r[2:0];
  assign pend       = w_r[6:0] & ~(7'h7f << pend_cnt);
  assign shamt      = tot_r - T_BYTE;
  assign emit_byte  = 8'(w_r >> shamt);
  assign pad        = 3'(4'd8 - {1'b0, pend_cnt});
  assign flush_byte = 8'({1'b0, pend} << pad);

  always_comb begin
    w_nxt        = w_r;
    tot_nxt      = tot_r;
    q_pop        = 1'b0;
    load_out     = 1'b0;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    out_last_nxt = out_last_r;
    if (emitting) begin
      if (slot_free) begin
        load_out     = 1'b1;
        tot_nxt      = tot_r - T_BYTE;
        out_data_nxt = {{(HTE_OUT_DW - 8){1'b0}}, emit_byte};
        out_user_nxt = 1'b1;
        out_last_nxt = (tot_nxt < T_BYTE);
      end
    end else if (!q_stat.empty) begin
      if (q_kind == KIND_ENC) begin
        q_pop   = 1'b1;
        w_nxt   = (WW'(pend) << q_len) | WW'(q_code);
        tot_nxt = tot_r + TW'(q_len);
      end else if (slot_free) begin
        q_pop        = 1'b1;
        load_out     = 1'b1;
        w_nxt        = '0;
        tot_nxt      = '0;
        out_last_nxt = 1'b1;
        if (pend_cnt != 3'd0) begin
          out_data_nxt = {{(HTE_OUT_DW - 11){1'b0}}, pad, flush_byte};
          out_user_nxt = 1'b1;
        end else begin
          out_data_nxt = '0;
          out_user_nxt = 1'b0;
        end
      end
    end
    out_vld_nxt = slot_free ? load_out : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= '0;
      tot_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      w_r       <= w_nxt;
      tot_r     <= tot_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;
  assign out_last  = out_last_r;

  `HTE_ASSERT(a_pad_on_flush, out_vld_r && (out_data_r[10:8] != 3'd0) |-> out_last_r && out_user_r, "padding outside a flush byte")
  `HTE_ASSERT(a_bare_report, out_vld_r && !out_user_r |-> out_last_r && (out_data_r == '0), "bare flush report not clean")
  `HTE_ASSERT_NEVER(a_pop_busy, q_pop && emitting, "queue read while bytes are still pending")

endmodule

// ----- design/huffman_table_encoder_packer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_table_encoder_packer_unit
// Code-table encoder with byte packer on stream channels.
// ----------------------------------------------------------------------------
// An encode passes the table read stage, the queue, the pending-bit register and the output
// register; a flush skips the pending-bit register. The packer takes no new queue entry while
// whole bytes are pending, and a flush waits for a free output slot. Loads stay in the front end.
// A 2-entry queue sits between the table read stage and the packer.
// Reset (synchronous, rst_n low) marks all table entries empty at once.
module huffman_table_encoder_packer_unit import hte_pkg::*; #(
  parameter int SYMBOLS   = HTE_SYMBOLS,
  parameter int CODE_BITS = HTE_CODE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] symbol, [39:8] code_bits, [45:40] code_length
  input  logic [HTE_IN_DW-1:0]  in_tdata,
  // [1:0] func
  input  logic [HTE_IN_UW-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] out_byte, [10:8] padding
  output logic [HTE_OUT_DW-1:0] out_tdata,
  // [0] byte_valid
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int LW = $clog2(CODE_BITS + 1);
  localparam int QW = 1 + LW + CODE_BITS;

  hte_qstat_t    q_stat;
  logic          q_push, q_pop;
  logic [QW-1:0] q_wdata, q_rdata;

  hte_front #(
    .SYMBOLS  (SYMBOLS),
    .CODE_BITS(CODE_BITS),
    .LW       (LW),
    .QW       (QW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .func       (in_tuser),
    .symbol     (in_tdata[7:0]),
    .code_bits  (in_tdata[39:8]),
    .code_length(in_tdata[45:40]),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  hte_fifo #(
    .WIDTH(QW),
    .DEPTH(HTE_QDEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  hte_back #(
    .CODE_BITS(CODE_BITS),
    .LW       (LW),
    .QW       (QW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata),
    .out_user (out_tuser),
    .out_last (out_tlast)
  );

endmodule
